[rtl/core/spst_pkg.sv]
// shared types and constants for the sorted pair set table
package spst_pkg;

  // fixed widths of the request and response fields
  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned COUNT_OUT_W = 7;

  // defaults for the top level parameters
  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned DEF_KEY_BITS = 16;

  // request operation codes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } spst_op_e;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } spst_state_e;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp_en;  // register compare flags against the held key
    logic ins_en;  // shift larger entries up and drop the key in place
  } spst_cell_ctrl_t;

endpackage

[rtl/core/spst_if.sv]
// request and response channel interfaces of the sorted pair set table

// request channel: operation and key pair
interface spst_req_if
  import spst_pkg::*;
();
  logic                  valid;
  logic                  ready;
  spst_op_e              operation;
  logic [FIELD_W-1:0]    first_key;
  logic [FIELD_W-1:0]    second_key;

  modport source (output valid, output operation, output first_key, output second_key,
                  input ready);
  modport sink   (input valid, input operation, input first_key, input second_key,
                  output ready);
endinterface

// response channel: lookup and insert outcome
interface spst_rsp_if
  import spst_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   was_present;
  logic                   was_inserted;
  logic                   table_full;
  logic [COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, output was_present, output was_inserted,
                  output table_full, output entry_count, input ready);
  modport sink   (input valid, input was_present, input was_inserted,
                  input table_full, input entry_count, output ready);
endinterface

[rtl/core/spst_cell.sv]
// one table slot: holds a key pair, compares it and shifts it to the next slot
module spst_cell
  import spst_pkg::*;
#(
  parameter int unsigned KEY_BITS = DEF_KEY_BITS
) (
  input  logic                    clk_i,
  input  spst_cell_ctrl_t         ctrl_i,
  input  logic                    valid_i,       // slot index below the count
  input  logic [2*KEY_BITS-1:0]   key_i,         // first key in the upper half
  input  logic [2*KEY_BITS-1:0]   prev_entry_i,  // entry of the slot below
  input  logic                    prev_gt_i,     // slot below sorts above the key
  output logic [2*KEY_BITS-1:0]   entry_o,
  output logic                    gt_o,
  output logic                    eq_o
);

  logic [2*KEY_BITS-1:0] entry_q;
  logic                  gt_q, eq_q;

  // compare flags, an empty slot counts as larger than any key
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp_en) begin
      gt_q <= !valid_i || (entry_q > key_i);
      eq_q <= valid_i && (entry_q == key_i);
    end
  end

  // insert: larger slots take their neighbor, the boundary slot takes the key
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins_en && gt_q) begin
      entry_q <= prev_gt_i ? prev_entry_i : key_i;
    end
  end

  assign entry_o = entry_q;
  assign gt_o    = gt_q;
  assign eq_o    = eq_q;

endmodule

[rtl/core/sorted_pair_set_table_unit.sv]
// top level of the sorted pair set table: sequencer, count and chain of slots
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------------
//  req_i    | in  | valid / ready | operation, first_key, second_key
//  rsp_o    | out | valid / ready | was_present, was_inserted, table_full,
//           |     |               | entry_count
//
// each request passes through ST_CMP, which registers compare flags in every
// slot, then ST_UPD, which resolves presence and shifts the slots; a new
// request is taken in ST_UPD as the last one commits, so requests overlap.
// the response sits in an output register; the next request is worked on while
// it waits, and only its ST_UPD state stalls until the register is free.
// reset clears the count, the sequencer and the response valid; slot contents
// are never read above the count and need no clearing.
module sorted_pair_set_table_unit
  import spst_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY,
  parameter int unsigned KEY_BITS = DEF_KEY_BITS
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  spst_req_if.sink   req_i,
  spst_rsp_if.source rsp_o
);

  localparam int unsigned CntW   = $clog2(CAPACITY + 1);
  localparam int unsigned CntExtW = (CntW > COUNT_OUT_W) ? CntW : COUNT_OUT_W;
  localparam int unsigned KeyExtW = (KEY_BITS > FIELD_W) ? KEY_BITS : FIELD_W;
  localparam int unsigned EntW   = 2 * KEY_BITS;

  spst_state_e       state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  spst_op_e          op_q;
  logic [EntW-1:0]   key_q;

  logic              rsp_valid_q;
  logic              rsp_present_q, rsp_inserted_q, rsp_full_q;
  logic [COUNT_OUT_W-1:0] rsp_count_q;

  logic [KeyExtW-1:0] first_ext, second_ext;
  logic [CntExtW-1:0] count_ext;
  logic               accept, commit, present, full, do_ins;
  spst_cell_ctrl_t    cell_ctrl;

  logic [CAPACITY-1:0]  cell_valid, cell_gt, cell_eq;
  logic [EntW-1:0]      cell_entry [CAPACITY];

  // key masking to the stored key width
  assign first_ext  = KeyExtW'(req_i.first_key);
  assign second_ext = KeyExtW'(req_i.second_key);

  // final cycle resolves when the response register is free
  assign commit    = (state_q == ST_UPD) && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = (state_q == ST_IDLE) || commit;
  assign accept    = req_i.valid && req_i.ready;

  // presence from the registered slot flags, room from the count
  assign present = |cell_eq;
  assign full    = (count_q == CntW'(CAPACITY));
  assign do_ins  = (op_q == OP_INSERT) && !present && !full;

  assign cell_ctrl.cmp_en = (state_q == ST_CMP);
  assign cell_ctrl.ins_en = commit && do_ins;

  assign count_d   = (commit && do_ins) ? count_q + CntW'(1) : count_q;
  assign count_ext = CntExtW'(count_d);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_CMP;
      ST_CMP:  state_d = ST_UPD;
      ST_UPD: begin
        if (commit) state_d = accept ? ST_CMP : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // held request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.operation;
      key_q <= {first_ext[KEY_BITS-1:0], second_ext[KEY_BITS-1:0]};
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_present_q  <= present;
      rsp_inserted_q <= do_ins;
      rsp_full_q     <= (op_q == OP_INSERT) && !present && full;
      rsp_count_q    <= count_ext[COUNT_OUT_W-1:0];
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.was_present  = rsp_present_q;
  assign rsp_o.was_inserted = rsp_inserted_q;
  assign rsp_o.table_full   = rsp_full_q;
  assign rsp_o.entry_count  = rsp_count_q;

  // chain of slots, slot 0 holds the smallest pair
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_valid[i] = CntW'(i) < count_q;

    if (i == 0) begin : g_head
      spst_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk_i        (clk_i),
        .ctrl_i       (cell_ctrl),
        .valid_i      (cell_valid[i]),
        .key_i        (key_q),
        .prev_entry_i (key_q),
        .prev_gt_i    (1'b0),
        .entry_o      (cell_entry[i]),
        .gt_o         (cell_gt[i]),
        .eq_o         (cell_eq[i])
      );
    end else begin : g_body
      spst_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk_i        (clk_i),
        .ctrl_i       (cell_ctrl),
        .valid_i      (cell_valid[i]),
        .key_i        (key_q),
        .prev_entry_i (cell_entry[i-1]),
        .prev_gt_i    (cell_gt[i-1]),
        .entry_o      (cell_entry[i]),
        .gt_o         (cell_gt[i]),
        .eq_o         (cell_eq[i])
      );
    end
  end

  // count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  // an insert grows the count by exactly one
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && do_ins) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not grow the count");

  // a dropped insert only happens with the table full
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (op_q == OP_INSERT) && !present && !do_ins) |-> full)
    else $error("insert dropped with room left");

  // at most one outcome flag per response
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> $onehot0({rsp_present_q, rsp_inserted_q, rsp_full_q}))
    else $error("conflicting response flags");

endmodule
